// ===== sv/mzhd_pkg.sv =====
// Package for the multi-zone hit detector: item opcodes, register map,
// fixed field widths and register reset values. No dependencies.
package mzhd_pkg;

   // Fixed widths of the channel fields
   localparam int ZONE_W   = 4;
   localparam int SAMPLE_W = 12;
   localparam int MASK_W   = 16;
   localparam int CFG_W    = 16;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_LOCKOUT   = 2'd1,
      REG_FLASH     = 2'd2,
      REG_WINDOW    = 2'd3
   } csr_reg_type;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2000;
   localparam logic [CFG_W-1:0]    LOCKOUT_RESET   = 16'd150;
   localparam logic [CFG_W-1:0]    FLASH_RESET     = 16'd200;
   localparam logic [CFG_W-1:0]    WINDOW_RESET    = 16'd5;

endpackage

// ===== sv/multi_zone_hit_detector.sv =====
// Top level of the multi-zone hit detector: input register, per-zone timers,
// comparison window and result register. Depends on mzhd_pkg.
//
// Usage:
//   req_* carries one item per handshake word: a zone sample (opcode 0,
//   zone_index, sample_value) or a one-millisecond tick (opcode 1).
//   rsp_* returns exactly one word per accepted item: hit_valid, hit_zone and
//   hit_value (nonzero only on the tick that closes a window), plus the flash
//   mask and window_active as they stand after that item.
//   csr_* is an APB-style register port; registers sit at byte addresses 0,
//   4, 8, 12 (hit_threshold, lockout_ticks, flash_ticks, window_ticks),
//   pready is tied high. Write registers only while no item is in flight.
// Timing:
//   An accepted word is captured in the input register, processed by the
//   combinational state update once the result register can take it, and
//   lands in the result register, which drives rsp_valid.
//   Throughput is one word per cycle while rsp_ready stays high, set by the
//   update loop on the zone timers and window state.
// Reset (synchronous, active high): clears all zone timers and the window,
//   restores register defaults and empties both pipeline registers.
// Stall: while rsp_ready is low the result register holds, the input
//   register holds one more word, and req_ready drops once both are full.
module multi_zone_hit_detector
   import mzhd_pkg::*;
#(
   parameter int ZONES       = 16,
   parameter int SAMPLE_BITS = 12,
   parameter int TIMER_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [ZONE_W-1:0]     req_zone_index,
   input  logic [SAMPLE_W-1:0]   req_sample_value,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit_valid,
   output logic [ZONE_W-1:0]     rsp_hit_zone,
   output logic [SAMPLE_W-1:0]   rsp_hit_value,
   output logic [MASK_W-1:0]     rsp_flash_mask,
   output logic                  rsp_window_active,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Compare width of samples, index width of the zone arrays
   localparam int CMP_BITS  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int ZIDX_BITS = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] threshold_ff;
   logic [CFG_W-1:0]    lockout_ticks_ff;
   logic [CFG_W-1:0]    flash_ticks_ff;
   logic [CFG_W-1:0]    window_ticks_ff;
   logic                csr_write;
   csr_reg_type         csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_reg)
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(threshold_ff);
         REG_LOCKOUT:   csr_prdata = CSR_DATA_W'(lockout_ticks_ff);
         REG_FLASH:     csr_prdata = CSR_DATA_W'(flash_ticks_ff);
         REG_WINDOW:    csr_prdata = CSR_DATA_W'(window_ticks_ff);
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: input register and result register
   // ---------------------------------------------------------------------
   logic                s1_valid_ff;
   opcode_type          s1_opcode_ff;
   logic [ZONE_W-1:0]   s1_zone_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                rsp_valid_ff;
   logic                advance;     // result register can take a word
   logic                step;        // process the held word this cycle
   logic                req_take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Detector state
   // ---------------------------------------------------------------------
   logic [TIMER_BITS-1:0] lock_cnt_ff  [ZONES];
   logic [TIMER_BITS-1:0] flash_cnt_ff [ZONES];
   logic [TIMER_BITS-1:0] lock_cnt_in  [ZONES];
   logic [TIMER_BITS-1:0] flash_cnt_in [ZONES];
   logic                  window_ff, window_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [ZONE_W-1:0]     leader_zone_ff, leader_zone_in;
   logic [CMP_BITS-1:0]   leader_value_ff, leader_value_in;

   logic                  hit_valid_in;
   logic [ZONE_W-1:0]     hit_zone_in;
   logic [SAMPLE_W-1:0]   hit_value_in;
   logic [MASK_W-1:0]     flash_mask_in;

   logic                  rsp_hit_valid_ff;
   logic [ZONE_W-1:0]     rsp_hit_zone_ff;
   logic [SAMPLE_W-1:0]   rsp_hit_value_ff;
   logic [MASK_W-1:0]     rsp_flash_mask_ff;
   logic                  rsp_window_ff;

   logic [CMP_BITS-1:0]   sample_cmp;
   logic                  zone_ok;
   logic                  strike;
   logic [CFG_W-1:0]      need;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic                  close_window;
   logic [TIMER_BITS-1:0] lock_load, flash_load;
   logic [ZIDX_BITS-1:0]  zone_idx, winner_idx;

   assign sample_cmp = s1_sample_ff[CMP_BITS-1:0];
   assign zone_ok    = 32'(s1_zone_ff) < ZONES;
   assign zone_idx   = s1_zone_ff[ZIDX_BITS-1:0];
   assign winner_idx = leader_zone_ff[ZIDX_BITS-1:0];
   assign strike     = (s1_opcode_ff == OP_SAMPLE) && zone_ok &&
                       (lock_cnt_ff[zone_idx] == '0) &&
                       (sample_cmp >= threshold_ff[CMP_BITS-1:0]);

   // Window length zero acts as one
   assign need = (window_ticks_ff == '0) ? CFG_W'(1) : window_ticks_ff;
   assign elapsed_inc  = (elapsed_ff != TIMER_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign close_window = (s1_opcode_ff == OP_TICK) && window_ff &&
                         (32'(elapsed_inc) >= 32'(need));

   // Saturate loaded timer values at the counter maximum
   assign lock_load  = (32'(lockout_ticks_ff) > 32'(TIMER_MAX)) ? TIMER_MAX
                       : TIMER_BITS'(32'(lockout_ticks_ff));
   assign flash_load = (32'(flash_ticks_ff) > 32'(TIMER_MAX)) ? TIMER_MAX
                       : TIMER_BITS'(32'(flash_ticks_ff));

   always_comb begin
      window_in       = window_ff;
      elapsed_in      = elapsed_ff;
      leader_zone_in  = leader_zone_ff;
      leader_value_in = leader_value_ff;
      hit_valid_in    = 1'b0;
      hit_zone_in     = '0;
      hit_value_in    = '0;
      for (int z = 0; z < ZONES; z++) begin
         lock_cnt_in[z]  = lock_cnt_ff[z];
         flash_cnt_in[z] = flash_cnt_ff[z];
      end

      case (s1_opcode_ff)
         OP_SAMPLE: begin
            // open a window on the first strike, else keep the larger value
            if (strike && !window_ff) begin
               window_in       = 1'b1;
               elapsed_in      = '0;
               leader_zone_in  = s1_zone_ff;
               leader_value_in = sample_cmp;
            end else if (strike && (sample_cmp > leader_value_ff)) begin
               leader_zone_in  = s1_zone_ff;
               leader_value_in = sample_cmp;
            end
         end
         OP_TICK: begin
            // step timers down, stop at zero
            for (int z = 0; z < ZONES; z++) begin
               if (lock_cnt_ff[z] != '0) lock_cnt_in[z] = lock_cnt_ff[z] - 1'b1;
               if (flash_cnt_ff[z] != '0) flash_cnt_in[z] = flash_cnt_ff[z] - 1'b1;
            end
            if (window_ff) elapsed_in = elapsed_inc;
            if (close_window) begin
               hit_valid_in             = 1'b1;
               hit_zone_in              = leader_zone_ff;
               hit_value_in             = SAMPLE_W'(leader_value_ff);
               lock_cnt_in[winner_idx]  = lock_load;
               flash_cnt_in[winner_idx] = flash_load;
               window_in                = 1'b0;
               elapsed_in               = '0;
               leader_zone_in           = '0;
               leader_value_in          = '0;
            end
         end
         default: ;
      endcase

      flash_mask_in = '0;
      for (int z = 0; z < ZONES; z++) begin
         flash_mask_in[z] = (flash_cnt_in[z] != '0);
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= THRESHOLD_RESET;
         lockout_ticks_ff <= LOCKOUT_RESET;
         flash_ticks_ff   <= FLASH_RESET;
         window_ticks_ff  <= WINDOW_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         window_ff        <= 1'b0;
         elapsed_ff       <= '0;
         leader_zone_ff   <= '0;
         leader_value_ff  <= '0;
         for (int z = 0; z < ZONES; z++) begin
            lock_cnt_ff[z]  <= '0;
            flash_cnt_ff[z] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_reg)
               REG_THRESHOLD: threshold_ff     <= csr_pwdata[SAMPLE_W-1:0];
               REG_LOCKOUT:   lockout_ticks_ff <= csr_pwdata[CFG_W-1:0];
               REG_FLASH:     flash_ticks_ff   <= csr_pwdata[CFG_W-1:0];
               REG_WINDOW:    window_ticks_ff  <= csr_pwdata[CFG_W-1:0];
            endcase
         end

         // hold the input word until the result register frees up
         if (req_take) s1_valid_ff <= 1'b1;
         else if (step) s1_valid_ff <= 1'b0;

         if (step) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (step) begin
            window_ff       <= window_in;
            elapsed_ff      <= elapsed_in;
            leader_zone_ff  <= leader_zone_in;
            leader_value_ff <= leader_value_in;
            for (int z = 0; z < ZONES; z++) begin
               lock_cnt_ff[z]  <= lock_cnt_in[z];
               flash_cnt_ff[z] <= flash_cnt_in[z];
            end
         end
      end

      // payload, no reset needed
      if (req_take) begin
         s1_opcode_ff <= opcode_type'(req_opcode);
         s1_zone_ff   <= req_zone_index;
         s1_sample_ff <= req_sample_value;
      end
      if (step) begin
         rsp_hit_valid_ff  <= hit_valid_in;
         rsp_hit_zone_ff   <= hit_zone_in;
         rsp_hit_value_ff  <= hit_value_in;
         rsp_flash_mask_ff <= flash_mask_in;
         rsp_window_ff     <= window_in;
      end
   end

   assign rsp_hit_valid     = rsp_hit_valid_ff;
   assign rsp_hit_zone      = rsp_hit_zone_ff;
   assign rsp_hit_value     = rsp_hit_value_ff;
   assign rsp_flash_mask    = rsp_flash_mask_ff;
   assign rsp_window_active = rsp_window_ff;

`ifndef SYNTHESIS
   // A hit always closes the window it reports
   a_hit_closes_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_valid_ff |-> !rsp_window_ff)
      else $error("hit reported with window still open");

   // A stalled input word stays put until processed
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_opcode_ff) &&
      $stable(s1_zone_ff) && $stable(s1_sample_ff))
      else $error("input word lost or changed while stalled");

   // The window only closes on a processed tick
   a_close_on_tick: assert property (@(posedge clock) disable iff (reset)
      $fell(window_ff) |-> $past(reset) || $past(step && (s1_opcode_ff == OP_TICK)))
      else $error("window closed without a tick");

   // Window age is zero whenever no window is open
   a_elapsed_idle: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff != '0 |-> window_ff)
      else $error("window age nonzero with window closed");
`endif

endmodule

// ===== sim/multi_zone_hit_detector_tb.sv =====
// Self-checking testbench for the multi-zone hit detector: drives sample and
// tick words with random idling, predicts every result word and compares it.
// Depends on mzhd_pkg and multi_zone_hit_detector.
module multi_zone_hit_detector_tb
   import mzhd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      opcode_type            opcode;
      logic [ZONE_W-1:0]     zone;
      logic [SAMPLE_W-1:0]   value;
   } sensor_word_type;

   typedef struct packed {
      logic                  hit_valid;
      logic [ZONE_W-1:0]     hit_zone;
      logic [SAMPLE_W-1:0]   hit_value;
      logic [MASK_W-1:0]     flash_mask;
      logic                  window_active;
   } hit_report_type;

   // Every input starts at a known value
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_opcode = 1'b0;
   logic [ZONE_W-1:0]     req_zone_index = '0;
   logic [SAMPLE_W-1:0]   req_sample_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_hit_valid;
   logic [ZONE_W-1:0]     rsp_hit_zone;
   logic [SAMPLE_W-1:0]   rsp_hit_value;
   logic [MASK_W-1:0]     rsp_flash_mask;
   logic                  rsp_window_active;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   multi_zone_hit_detector i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_zone_index    (req_zone_index),
      .req_sample_value  (req_sample_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit_valid     (rsp_hit_valid),
      .rsp_hit_zone      (rsp_hit_zone),
      .rsp_hit_value     (rsp_hit_value),
      .rsp_flash_mask    (rsp_flash_mask),
      .rsp_window_active (rsp_window_active),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Words waiting for the driver, and result words the detector owes us
   sensor_word_type pending_words[$];
   hit_report_type  expected_reports[$];

   // Shadow of the register file, kept in step with every CSR write
   logic [SAMPLE_W-1:0] cfg_threshold = THRESHOLD_RESET;
   logic [CFG_W-1:0]    cfg_lockout   = LOCKOUT_RESET;
   logic [CFG_W-1:0]    cfg_flash     = FLASH_RESET;
   logic [CFG_W-1:0]    cfg_window    = WINDOW_RESET;

   // Shadow of the detector state: per-zone timers and the open window
   logic [CFG_W-1:0]    lock_left  [16];
   logic [CFG_W-1:0]    flash_left [16];
   logic                window_open = 1'b0;
   logic [CFG_W-1:0]    window_age  = '0;
   logic [ZONE_W-1:0]   lead_zone   = '0;
   logic [SAMPLE_W-1:0] lead_value  = '0;

   bit          idle_enable = 1'b0;
   int          send_gap = 0;
   int          ready_gap = 0;
   int          fail_count = 0;
   int          words_sent = 0;
   int          hits_seen = 0;
   int          csr_writes = 0;
   sensor_word_type next_word;
   hit_report_type  front_report;

   initial begin
      for (int z = 0; z < 16; z++) begin
         lock_left[z]  = '0;
         flash_left[z] = '0;
      end
   end

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Work out the result word for one accepted input word and queue it.
   // Ticks first age the zone timers, then the window, then check for closing.
   task automatic predict_hit(input sensor_word_type w);
      hit_report_type   rep;
      logic [CFG_W-1:0] need;
      int               z;
      rep = '0;
      if (w.opcode == OP_SAMPLE) begin
         if (lock_left[w.zone] == 0 && w.value >= cfg_threshold) begin
            if (!window_open) begin
               window_open = 1'b1;
               window_age  = '0;
               lead_zone   = w.zone;
               lead_value  = w.value;
            end else if (w.value > lead_value) begin
               // only a strictly larger peak takes over the lead
               lead_zone  = w.zone;
               lead_value = w.value;
            end
         end
      end else begin
         // a window length of zero behaves as one tick
         need = (cfg_window == 0) ? CFG_W'(1) : cfg_window;
         for (z = 0; z < 16; z++) begin
            if (lock_left[z] != 0) lock_left[z] = lock_left[z] - 1'b1;
            if (flash_left[z] != 0) flash_left[z] = flash_left[z] - 1'b1;
         end
         if (window_open) begin
            if (window_age != '1) window_age = window_age + 1'b1;
            if (window_age >= need) begin
               rep.hit_valid = 1'b1;
               rep.hit_zone  = lead_zone;
               rep.hit_value = lead_value;
               lock_left[lead_zone]  = cfg_lockout;
               flash_left[lead_zone] = cfg_flash;
               window_open = 1'b0;
               window_age  = '0;
               lead_zone   = '0;
               lead_value  = '0;
            end
         end
      end
      for (z = 0; z < 16; z++) rep.flash_mask[z] = (flash_left[z] != 0);
      rep.window_active = window_open;
      expected_reports.push_back(rep);
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Driver: predict on acceptance, then hold, idle or present the next word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_hit('{opcode_type'(req_opcode), req_zone_index, req_sample_value});
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 11) == 0) begin
               // start an idle burst
               send_gap  = $urandom_range(1, 13) - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_valid        <= 1'b1;
               req_opcode       <= next_word.opcode;
               req_zone_index   <= next_word.zone;
               req_sample_value <= next_word.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result word with the oldest expectation,
   // and stall the result channel in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result word arrived with no expectation pending");
               fail_count++;
            end else begin
               front_report = expected_reports.pop_front();
               check_field("hit_valid", 16'(front_report.hit_valid), 16'(rsp_hit_valid));
               check_field("hit_zone", 16'(front_report.hit_zone), 16'(rsp_hit_zone));
               check_field("hit_value", 16'(front_report.hit_value), 16'(rsp_hit_value));
               check_field("flash_mask", front_report.flash_mask, rsp_flash_mask);
               check_field("window_active", 16'(front_report.window_active),
                           16'(rsp_window_active));
               if (rsp_hit_valid) hits_seen++;
            end
         end
         if (ready_gap > 0) begin
            ready_gap--;
            rsp_ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 11) == 0) begin
            ready_gap = $urandom_range(1, 13) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // APB write: setup cycle, then access cycle; mirror the value in the shadow
   task automatic csr_write(input csr_reg_type reg_sel, input logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_sel)
         REG_THRESHOLD: cfg_threshold = data[SAMPLE_W-1:0];
         REG_LOCKOUT:   cfg_lockout   = data;
         REG_FLASH:     cfg_flash     = data;
         REG_WINDOW:    cfg_window    = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_timing(input logic [SAMPLE_W-1:0] thr, input logic [CFG_W-1:0] lock,
                             input logic [CFG_W-1:0] flash, input logic [CFG_W-1:0] win);
      csr_write(REG_THRESHOLD, CFG_W'(thr));
      csr_write(REG_LOCKOUT, lock);
      csr_write(REG_FLASH, flash);
      csr_write(REG_WINDOW, win);
   endtask

   // Hold off until every word is accepted and every result has come back,
   // then let the two-stage pipeline settle
   task automatic wait_drained();
      forever begin
         @(negedge clock);
         if (pending_words.size() == 0 && !req_valid && expected_reports.size() == 0)
            break;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic queue_word(input opcode_type op, input int zone, input int value);
      pending_words.push_back('{op, ZONE_W'(zone), SAMPLE_W'(value)});
   endtask

   // Random word: roughly a third ticks, samples biased at or above threshold
   // so windows open often; the rest is noise across the full range
   task automatic queue_random_word();
      int value;
      case ($urandom_range(0, 9))
         0, 1, 2: value = $urandom_range(0, 4095);
         3:       value = int'(cfg_threshold);
         default: value = $urandom_range(cfg_threshold, 4095);
      endcase
      if ($urandom_range(0, 99) < 32)
         queue_word(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 4095));
      else
         queue_word(OP_SAMPLE, $urandom_range(0, 15), value);
   endtask

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset registers: below, equal and above threshold, equal
      // peak keeps the leader, larger one takes over, window closes on the
      // fifth tick, locked zone is ignored, tick fields are don't-care
      queue_word(OP_SAMPLE, 0, 0);
      queue_word(OP_SAMPLE, 15, 1999);
      queue_word(OP_SAMPLE, 5, 2000);
      queue_word(OP_SAMPLE, 9, 2000);
      queue_word(OP_SAMPLE, 12, 4095);
      queue_word(OP_SAMPLE, 3, 4094);
      queue_word(OP_TICK, 15, 4095);
      repeat (4) queue_word(OP_TICK, 0, 0);
      queue_word(OP_SAMPLE, 12, 4095);
      queue_word(OP_SAMPLE, 7, 3000);
      queue_word(OP_TICK, 10, 2730);
      wait_drained();

      // Directed, all registers zero: window of zero acts as one tick,
      // zero flash never lights, an equal peak keeps the leader
      set_timing('0, '0, '0, '0);
      @(negedge clock);
      queue_word(OP_SAMPLE, 0, 0);
      queue_word(OP_TICK, 5, 1365);
      queue_word(OP_SAMPLE, 7, 0);
      queue_word(OP_TICK, 0, 0);
      queue_word(OP_SAMPLE, 15, 4095);
      queue_word(OP_SAMPLE, 1, 4095);
      queue_word(OP_TICK, 0, 0);
      wait_drained();

      // Random phases; every phase boundary drains the pipeline first
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 0)
            set_timing('1, '1, '1, '1);
         else if (phase == 1)
            set_timing('0, CFG_W'(1), CFG_W'(1), CFG_W'(1));
         else if (phase == 6)
            set_timing(SAMPLE_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 20)),
                       '1, CFG_W'($urandom_range(0, 3)));
         else
            set_timing(SAMPLE_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 40)),
                       ($urandom_range(0, 9) == 0) ? CFG_W'(0)
                                                   : CFG_W'($urandom_range(1, 60)),
                       CFG_W'($urandom_range(0, 8)));
         @(negedge clock);
         // leave some phases without idling, and none at the end of the run
         idle_enable = (phase < 10) && (phase % 4 != 3);
         repeat ((phase == 0) ? 80 : 143) queue_random_word();
         wait_drained();
      end

      $display("Run covered %0d sensor words, %0d reported hits, %0d register writes",
               words_sent, hits_seen, csr_writes);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
